// ----- rtl/psr_pkg.sv -----
`default_nettype none
package psr_pkg;

    // value width and derived widths
    localparam int VALUE_WIDTH = 64;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    // small primes used for the divisibility screen and as witness bases
    localparam int NUM_BASES = 12;
    localparam int BASE_W    = 6;
    localparam int REM_W     = BASE_W + 1;
    localparam int IDX_W     = $clog2(NUM_BASES);

    typedef logic [VALUE_WIDTH-1:0] t_value;

    localparam t_value VAL_MAX = '1;

    localparam logic [NUM_BASES-1:0][BASE_W-1:0] BASES = {
        6'd37, 6'd31, 6'd29, 6'd23, 6'd19, 6'd17,
        6'd13, 6'd11, 6'd7,  6'd5,  6'd3,  6'd2
    };

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BASES - 1);

    // modular multiplier request and response
    typedef struct packed {
        logic   start;
        t_value a;
        t_value b;
        t_value m;
    } t_mul_req;

    typedef struct packed {
        logic   busy;
        logic   done;
        t_value res;
    } t_mul_rsp;

    // small prime screen response
    typedef struct packed {
        logic busy;
        logic done;
        logic any_zero;
    } t_small_rsp;

endpackage
`default_nettype wire

// ----- rtl/psr_in_if.sv -----
`default_nettype none
interface psr_in_if import psr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value draw;
    t_value range_low;
    t_value range_high;

    modport source (output valid, output draw, output range_low, output range_high,
                    input ready);
    modport sink   (input valid, input draw, input range_low, input range_high,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/psr_out_if.sv -----
`default_nettype none
interface psr_out_if import psr_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   found;
    t_value prime_value;

    modport source (output valid, output found, output prime_value, input ready);
    modport sink   (input valid, input found, input prime_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/psr_modadd.sv -----
`default_nettype none
module psr_modadd import psr_pkg::*; (
    input  t_value i_x,
    input  t_value i_y,
    input  t_value i_m,
    output t_value o_sum
);

    logic [VALUE_WIDTH:0] sum;
    logic [VALUE_WIDTH:0] diff;

    // add, then fold back once; operands are below the modulus
    always_comb begin
        sum  = {1'b0, i_x} + {1'b0, i_y};
        diff = sum - {1'b0, i_m};
        if (sum >= {1'b0, i_m}) begin
            o_sum = diff[VALUE_WIDTH-1:0];
        end else begin
            o_sum = sum[VALUE_WIDTH-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/psr_mulmod.sv -----
`default_nettype none
module psr_mulmod import psr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic             r_phase;
    logic [CNT_W-1:0] r_cnt;
    t_value           r_acc;
    t_value           r_a;
    t_value           r_b;
    t_value           r_m;

    t_value add_y;
    t_value add_sum;

    // double in phase 0, add the multiplicand in phase 1
    assign add_y = r_phase ? r_a : r_acc;

    psr_modadd u_add (
        .i_x   (r_acc),
        .i_y   (add_y),
        .i_m   (r_m),
        .o_sum (add_sum)
    );

    // walk the multiplier from its top bit, one modular add per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy  <= 1'b1;
                    r_phase <= 1'b0;
                    r_cnt   <= CNT_W'(VALUE_WIDTH - 1);
                    r_acc   <= '0;
                    r_a     <= i_req.a;
                    r_b     <= i_req.b;
                    r_m     <= i_req.m;
                end
            end else begin
                r_acc <= add_sum;
                if (!r_phase && r_b[VALUE_WIDTH-1]) begin
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    r_b     <= {r_b[VALUE_WIDTH-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;

endmodule
`default_nettype wire

// ----- rtl/psr_smallrem.sv -----
`default_nettype none
module psr_smallrem import psr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_value     i_value,
    output t_small_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    t_value            r_val;
    logic [BASE_W-1:0] r_rem [NUM_BASES];
    logic [BASE_W-1:0] n_rem [NUM_BASES];
    logic [REM_W-1:0]  shifted [NUM_BASES];
    logic              any_zero;

    // one remainder lane per small prime: r = (2r + bit) mod p
    always_comb begin
        for (int i = 0; i < NUM_BASES; i++) begin
            shifted[i] = {r_rem[i], r_val[VALUE_WIDTH-1]};
            if (shifted[i] >= REM_W'(BASES[i])) begin
                n_rem[i] = BASE_W'(shifted[i] - REM_W'(BASES[i]));
            end else begin
                n_rem[i] = BASE_W'(shifted[i]);
            end
        end
    end

    // flag any lane with a zero remainder
    always_comb begin
        any_zero = 1'b0;
        for (int i = 0; i < NUM_BASES; i++) begin
            if (r_rem[i] == '0) begin
                any_zero = 1'b1;
            end
        end
    end

    // shift the value in, most significant bit first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(VALUE_WIDTH - 1);
                    r_val  <= i_value;
                    for (int i = 0; i < NUM_BASES; i++) begin
                        r_rem[i] <= '0;
                    end
                end
            end else begin
                r_val <= {r_val[VALUE_WIDTH-2:0], 1'b0};
                for (int i = 0; i < NUM_BASES; i++) begin
                    r_rem[i] <= n_rem[i];
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.any_zero = any_zero;

endmodule
`default_nettype wire

// ----- rtl/prime_search_in_range_core.sv -----
// Next-prime search inside a bounded window.
// Input channel i_in carries draw, range_low and range_high; output channel
// o_out carries found and prime_value. Both use valid/ready, and a transfer
// happens at a rising edge with valid and ready high.
// The start is raised to 2 when below it and made odd when even above 2;
// candidates then step by 2 until a prime is found, range_high is passed or
// the top of the value range is reached. Each candidate gets a bound check,
// a screen against the primes 2..37 (a bit-serial remainder pass, one bit a
// cycle, then a read of the lanes), a step to the next candidate, and, when
// it survives, a strong-probable-prime test over the same 12 bases.
// That test runs on one modular multiplier built around a single modular
// adder: one product takes one or two adds per multiplier bit, and each
// base needs up to 126 products. The total search time is the sum over
// all candidates visited and depends on the data.
// i_in.ready is high only while no search is running. The result waits in
// an output register; a new item is accepted while it waits, and a finished
// search holds until the register is free. Reset (i_rst_n low at a clock
// edge) drops any search and any pending result.
`default_nettype none
module prime_search_in_range_core import psr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psr_in_if.sink    i_in,
    psr_out_if.source o_out
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_SMALL    = 4'd2;
    localparam logic [3:0] S_NEXT     = 4'd3;
    localparam logic [3:0] S_TZ       = 4'd4;
    localparam logic [3:0] S_POW_INIT = 4'd5;
    localparam logic [3:0] S_POW_STEP = 4'd6;
    localparam logic [3:0] S_WAIT_A   = 4'd7;
    localparam logic [3:0] S_WAIT_B   = 4'd8;
    localparam logic [3:0] S_POW_END  = 4'd9;
    localparam logic [3:0] S_SQ_LOOP  = 4'd10;
    localparam logic [3:0] S_WAIT_S   = 4'd11;
    localparam logic [3:0] S_FINISH   = 4'd12;

    logic [3:0]       r_state, n_state;
    t_value           r_x, n_x;
    t_value           r_low, n_low;
    t_value           r_high, n_high;
    t_value           r_d, n_d;
    logic [CNT_W-1:0] r_twos, n_twos;
    logic [CNT_W-1:0] r_sq, n_sq;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_value           r_acc, n_acc;
    t_value           r_base, n_base;
    t_value           r_exp, n_exp;
    logic             r_found, n_found;
    logic             r_out_valid, n_out_valid;
    logic             r_out_found, n_out_found;
    t_value           r_out_prime, n_out_prime;

    logic       in_xfer;
    logic       small_start;
    logic       small_match;
    t_value     x_m1;
    t_value     start_x;
    t_mul_req   mul_req;
    t_mul_rsp   mul_rsp;
    t_small_rsp small_rsp;

    assign in_xfer = i_in.valid && i_in.ready;
    assign x_m1    = r_x - t_value'(1);

    // shared units
    psr_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    psr_smallrem u_smallrem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (small_start),
        .i_value (r_x),
        .o_rsp   (small_rsp)
    );

    // adjust the drawn start: at least 2, odd above 2
    always_comb begin
        start_x = i_in.draw;
        if (i_in.draw < t_value'(2)) begin
            start_x = t_value'(2);
        end else if (!i_in.draw[0] && i_in.draw != t_value'(2)) begin
            start_x = i_in.draw + t_value'(1);
        end
    end

    // candidate equal to one of the small primes
    always_comb begin
        small_match = 1'b0;
        for (int i = 0; i < NUM_BASES; i++) begin
            if (r_x == t_value'(BASES[i])) begin
                small_match = 1'b1;
            end
        end
    end

    // search sequencer
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_low       = r_low;
        n_high      = r_high;
        n_d         = r_d;
        n_twos      = r_twos;
        n_sq        = r_sq;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_base      = r_base;
        n_exp       = r_exp;
        n_found     = r_found;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_found = r_out_found;
        n_out_prime = r_out_prime;
        small_start = 1'b0;
        mul_req     = '0;
        mul_req.m   = r_x;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_x     = start_x;
                    n_low   = i_in.range_low;
                    n_high  = i_in.range_high;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_x > r_high) begin
                    n_found = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    small_start = 1'b1;
                    n_state     = S_SMALL;
                end
            end
            S_SMALL: begin
                if (small_rsp.done) begin
                    if (small_match) begin
                        n_found = (r_x >= r_low);
                        n_state = S_FINISH;
                    end else if (small_rsp.any_zero) begin
                        n_state = S_NEXT;
                    end else begin
                        n_d     = x_m1;
                        n_twos  = '0;
                        n_state = S_TZ;
                    end
                end
            end
            S_NEXT: begin
                if (r_x > (VAL_MAX - t_value'(2))) begin
                    n_found = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    n_x     = r_x + t_value'(2);
                    n_state = S_CHECK;
                end
            end
            S_TZ: begin
                if (!r_d[0]) begin
                    n_d    = r_d >> 1;
                    n_twos = r_twos + CNT_W'(1);
                end else begin
                    n_idx   = '0;
                    n_state = S_POW_INIT;
                end
            end
            S_POW_INIT: begin
                n_acc   = t_value'(1);
                n_base  = t_value'(BASES[r_idx]);
                n_exp   = r_d;
                n_state = S_POW_STEP;
            end
            S_POW_STEP: begin
                if (r_exp == '0) begin
                    n_state = S_POW_END;
                end else if (r_exp[0]) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_acc;
                    mul_req.b     = r_base;
                    n_state       = S_WAIT_A;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_base;
                    mul_req.b     = r_base;
                    n_state       = S_WAIT_B;
                end
            end
            S_WAIT_A: begin
                if (mul_rsp.done) begin
                    n_acc         = mul_rsp.res;
                    mul_req.start = 1'b1;
                    mul_req.a     = r_base;
                    mul_req.b     = r_base;
                    n_state       = S_WAIT_B;
                end
            end
            S_WAIT_B: begin
                if (mul_rsp.done) begin
                    n_base  = mul_rsp.res;
                    n_exp   = r_exp >> 1;
                    n_state = S_POW_STEP;
                end
            end
            S_POW_END: begin
                if (r_acc == t_value'(1) || r_acc == x_m1) begin
                    if (r_idx == LAST_IDX) begin
                        n_found = (r_x >= r_low);
                        n_state = S_FINISH;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_POW_INIT;
                    end
                end else begin
                    n_sq    = CNT_W'(1);
                    n_state = S_SQ_LOOP;
                end
            end
            S_SQ_LOOP: begin
                if (r_sq < r_twos) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_acc;
                    mul_req.b     = r_acc;
                    n_state       = S_WAIT_S;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_WAIT_S: begin
                if (mul_rsp.done) begin
                    n_acc = mul_rsp.res;
                    if (mul_rsp.res == x_m1) begin
                        if (r_idx == LAST_IDX) begin
                            n_found = (r_x >= r_low);
                            n_state = S_FINISH;
                        end else begin
                            n_idx   = r_idx + IDX_W'(1);
                            n_state = S_POW_INIT;
                        end
                    end else begin
                        n_sq    = r_sq + CNT_W'(1);
                        n_state = S_SQ_LOOP;
                    end
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_prime = r_found ? r_x : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // register control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_x         <= n_x;
        r_low       <= n_low;
        r_high      <= n_high;
        r_d         <= n_d;
        r_twos      <= n_twos;
        r_sq        <= n_sq;
        r_idx       <= n_idx;
        r_acc       <= n_acc;
        r_base      <= n_base;
        r_exp       <= n_exp;
        r_found     <= n_found;
        r_out_found <= n_out_found;
        r_out_prime <= n_out_prime;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.prime_value = r_out_prime;

    // a product is requested only while the multiplier is free
    a_mul_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    // a remainder pass is started only while the screen is free
    a_small_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        small_start |-> !small_rsp.busy)
        else $error("remainder pass started while busy");

    // the witness test sees only odd candidates above the screened primes
    a_witness_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POW_INIT) |-> (r_x[0] && r_x > t_value'(BASES[LAST_IDX])))
        else $error("witness test on a screened candidate");

    // a reported prime is odd or equal to 2
    a_found_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.found) |->
            (o_out.prime_value[0] || o_out.prime_value == t_value'(2)))
        else $error("even value reported as prime");

    // a miss carries a zero value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.prime_value == '0))
        else $error("nonzero value on a miss");

    // an accepted item starts with the bound check
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CHECK))
        else $error("transfer did not start a search");

endmodule
`default_nettype wire

// ----- test/prime_search_in_range_core_test.sv -----
`timescale 1ns / 100ps
module prime_search_in_range_core_test import psr_pkg::*; ();

    // Most of the slowest run is spent in the full-width searches.
    localparam int unsigned RUN_LIMIT          = 50_000_000;
    localparam int unsigned OUTPUT_HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES        = 200;
    localparam int unsigned RANDOM_PER_PHASE   = 36;

    // Primes for the divisibility screen; they double as the witness bases.
    localparam logic [11:0][7:0] SCREEN_PRIMES = {
        8'd37, 8'd31, 8'd29, 8'd23, 8'd19, 8'd17,
        8'd13, 8'd11, 8'd7,  8'd5,  8'd3,  8'd2
    };

    typedef struct packed {
        logic   found;
        t_value prime_value;
        t_value draw;
    } t_prime_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psr_in_if  in_ch ();
    psr_out_if out_ch ();

    t_prime_result pending_primes[$];
    int unsigned   mismatch_count    = 0;
    int unsigned   cycle_count       = 0;
    int unsigned   sender_idle_pct   = 0;
    int unsigned   receiver_idle_pct = 0;
    logic          output_hold       = 1'b0;

    prime_search_in_range_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // (a * b) mod m through a double-width product
    function automatic t_value mod_product(t_value a, t_value b, t_value m);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        return t_value'(wide % {64'd0, m});
    endfunction

    function automatic t_value mod_power(t_value base, t_value e, t_value m);
        t_value acc;
        t_value sq;
        acc = 1;
        sq  = base % m;
        while (e != 0) begin
            if (e[0]) begin
                acc = mod_product(acc, sq, m);
            end
            sq = mod_product(sq, sq, m);
            e  = e >> 1;
        end
        return acc;
    endfunction

    // Screen by small primes, then a strong-probable-prime test on every screen
    // prime as witness; exact over the whole 64-bit range.
    function automatic bit is_prime_value(t_value n);
        t_value odd_part;
        t_value x;
        int     twos;
        int     r;
        bit     settled;
        bit     verdict;
        bit     witness_ok;
        settled = 1'b0;
        verdict = 1'b1;
        if (n < 2) begin
            return 1'b0;
        end
        for (int i = 0; i < 12; i++) begin
            if (!settled && n == t_value'(SCREEN_PRIMES[i])) begin
                settled = 1'b1;
            end else if (!settled && n % t_value'(SCREEN_PRIMES[i]) == 0) begin
                settled = 1'b1;
                verdict = 1'b0;
            end
        end
        if (settled) begin
            return verdict;
        end
        odd_part = n - 1;
        twos     = 0;
        while (!odd_part[0]) begin
            odd_part = odd_part >> 1;
            twos++;
        end
        for (int i = 0; i < 12; i++) begin
            x = mod_power(t_value'(SCREEN_PRIMES[i]), odd_part, n);
            witness_ok = (x == 1) || (x == n - 1);
            for (r = 1; r < twos && !witness_ok; r++) begin
                x = mod_product(x, x, n);
                witness_ok = (x == n - 1);
            end
            if (!witness_ok) begin
                verdict = 1'b0;
            end
        end
        return verdict;
    endfunction

    // Walk odd candidates from the adjusted start until a prime, the high bound,
    // or the top of the value range.
    function automatic t_prime_result predict_search(t_value draw, t_value low, t_value high);
        t_prime_result res;
        t_value        cand;
        bit            searching;
        res.found       = 1'b0;
        res.prime_value = '0;
        res.draw        = draw;
        cand = draw;
        if (cand < 2) begin
            cand = 2;
        end
        if (cand > 2 && !cand[0]) begin
            cand = cand + 1;
        end
        searching = 1'b1;
        while (searching) begin
            if (cand > high) begin
                searching = 1'b0;
            end else if (is_prime_value(cand)) begin
                searching = 1'b0;
                if (cand >= low) begin
                    res.found       = 1'b1;
                    res.prime_value = cand;
                end
            end else if (cand > VAL_MAX - 2) begin
                searching = 1'b0;
            end else begin
                cand = cand + 2;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, t_value got, t_value want, t_value draw);
        mismatch_count++;
        $display("[%0t] mismatch on %s for draw %0h: got %0h, want %0h",
                 $time, what, draw, got, want);
    endtask

    // Predict on each input transfer, compare on each output transfer.
    always @(posedge i_clk) begin : check_results
        t_prime_result due;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                pending_primes.push_back(
                    predict_search(in_ch.draw, in_ch.range_low, in_ch.range_high));
            end
            if (out_ch.ready && out_ch.valid !== 1'b0) begin
                if (pending_primes.size() == 0) begin
                    report_mismatch("result with none pending", out_ch.prime_value, '0, '0);
                end else begin
                    due = pending_primes.pop_front();
                    if (out_ch.found !== due.found) begin
                        report_mismatch("found", t_value'(out_ch.found),
                                        t_value'(due.found), due.draw);
                    end
                    if (out_ch.prime_value !== due.prime_value) begin
                        report_mismatch("prime_value", out_ch.prime_value,
                                        due.prime_value, due.draw);
                    end
                end
            end
        end
    end

    // Drive the output ready: random stalls, or a forced hold.
    initial begin : receiver
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= !output_hold && ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Offer one search and hold it until the transfer.
    task automatic send_search(t_value draw, t_value low, t_value high);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.draw       <= draw;
        in_ch.range_low  <= low;
        in_ch.range_high <= high;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
    endtask

    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_primes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Small start, mostly a low bound at or under it; sometimes the low bound sits above.
    task automatic send_tiny_search();
        int unsigned d32;
        int unsigned lo32;
        d32  = $urandom_range(0, 300);
        lo32 = ($urandom_range(0, 99) < 15) ? d32 + $urandom_range(1, 20)
                                            : $urandom_range(0, d32);
        send_search(t_value'(d32), t_value'(lo32), t_value'(d32 + $urandom_range(0, 60)));
    endtask

    task automatic send_random_search();
        t_value      d;
        t_value      lo;
        t_value      hi;
        t_value      swap;
        int unsigned pick;
        int unsigned d32;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            send_tiny_search();
        end else if (pick < 70) begin
            d32 = $urandom_range(0, 65535);
            d   = t_value'(d32);
            lo  = t_value'($urandom_range(0, d32));
            hi  = d + $urandom_range(0, 200);
            send_search(d, lo, hi);
        end else if (pick < 85) begin
            // full random fields with the high bound under the start: stops at once
            d  = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            if (hi >= d) begin
                swap = hi;
                hi   = d;
                d    = swap;
            end
            if (hi == d && d != 0) begin
                hi = d - 1;
            end
            send_search(d, lo, hi);
        end else if (pick < 95) begin
            // low bound above the high bound: nothing can qualify
            d32 = $urandom_range(0, 300);
            d   = t_value'(d32);
            hi  = d + $urandom_range(0, 40);
            lo  = hi + $urandom_range(1, 1000);
            send_search(d, lo, hi);
        end else begin
            // full-width start with a narrow window to bound the search time
            d  = {$urandom, $urandom};
            hi = d + $urandom_range(0, 64);
            if (hi < d) begin
                hi = VAL_MAX;
            end
            lo = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : d;
            send_search(d, lo, hi);
        end
    endtask

    // Starts below 2, at 2, even starts, starts on and between screen primes.
    task automatic test_small_starts();
        send_search(0, 0, VAL_MAX);
        send_search(1, 0, VAL_MAX);
        send_search(2, 0, VAL_MAX);
        send_search(3, 0, VAL_MAX);
        send_search(4, 0, VAL_MAX);
        send_search(25, 0, 100);
        send_search(37, 0, 37);
        send_search(38, 0, 100);
        send_search(8, 0, 8);
    endtask

    // Prime under the low bound, crossed bounds, start over the high bound.
    task automatic test_bound_cases();
        send_search(10, 12, 100);
        send_search(10, 100, 50);
        send_search(100, 0, 50);
        send_search(0, 0, 0);
        send_search(2, 3, 2);
    endtask

    // Step past the top, the largest 64-bit prime, primes near 2^31 and 2^32.
    task automatic test_top_of_range();
        send_search(VAL_MAX, VAL_MAX, VAL_MAX);
        send_search(VAL_MAX - 1, 0, VAL_MAX);
        send_search(VAL_MAX - 58, VAL_MAX - 58, VAL_MAX);
        send_search(64'h7FFF_FFFE, 64'h7FFF_FFFF, VAL_MAX);
        send_search(64'hFFFF_FFFA, 0, 64'h1_0000_0000);
    endtask

    task automatic test_random_searches(int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_random_search();
        end
    endtask

    // Hold the output off while quick searches keep coming, so the input stalls.
    task automatic test_output_hold();
        fork
            begin
                output_hold <= 1'b1;
                repeat (OUTPUT_HOLD_CYCLES) @(posedge i_clk);
                output_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 8; i++) begin
            if (i % 2 == 0) begin
                send_search(t_value'($urandom_range(0, 37)), 0, 37);
            end else begin
                send_search(t_value'($urandom_range(1000, 5000)), 0, 999);
            end
        end
    endtask

    // Let the block drain fully between two bursts.
    task automatic test_drain_pause();
        repeat (4) send_tiny_search();
        pause_until_drained();
        repeat (4) send_tiny_search();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.draw       <= '0;
        in_ch.range_low  <= '0;
        in_ch.range_high <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct   = 32;
        receiver_idle_pct <= 53;
        test_small_starts();
        test_bound_cases();
        test_top_of_range();
        test_random_searches(RANDOM_PER_PHASE);

        sender_idle_pct   = 53;
        receiver_idle_pct <= 32;
        test_random_searches(RANDOM_PER_PHASE);

        sender_idle_pct   = 0;
        receiver_idle_pct <= 0;
        test_output_hold();
        test_drain_pause();
        test_random_searches(RANDOM_PER_PHASE);

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/psr_pkg.sv
rtl/psr_in_if.sv
rtl/psr_out_if.sv
rtl/psr_modadd.sv
rtl/psr_mulmod.sv
rtl/psr_smallrem.sv
rtl/prime_search_in_range_core.sv
test/prime_search_in_range_core_test.sv
